FILE: hw/rtl/fba_pkg.sv
// Shared types, codes and constants of the frame bitmap allocator.
package fba_pkg;

  // Field and storage sizes
  localparam int FRAME_COUNT_DEF = 4096;
  localparam int FRAME_BITS      = 12;
  localparam int WORD_BITS       = 32;
  localparam int BIT_IDX_W       = 5;
  localparam int LIMIT_W         = 13;
  localparam int CNT_W           = 8;
  localparam int MAX_WORDS       = 128;
  localparam int MODE_W          = 2;
  localparam int STATUS_W        = 2;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'h1000;

  // Request kinds
  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TEST  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_HELD = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

  // Word unit operations
  localparam logic WOP_MARK = 1'b0;
  localparam logic WOP_FREE = 1'b1;

  // Status of one inspected bitmap word
  typedef struct packed {
    logic                 full;
    logic [BIT_IDX_W-1:0] low_idx;
    logic                 bit_val;
  } word_stat_t;

  // One result item
  typedef struct packed {
    logic [FRAME_BITS-1:0] frame_out;
    logic                  present;
    logic                  rw_bit;
    logic                  user_bit;
    logic [STATUS_W-1:0]   status;
    logic                  frame_used;
  } result_t;

endpackage

FILE: hw/rtl/fba_ram.sv
// Generic simple dual-port RAM with registered read.
module fba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/fba_word_unit.sv
// Shared bitmap word unit: full test, lowest clear bit, bit set and clear.
module fba_word_unit (
  input  logic [fba_pkg::WORD_BITS-1:0] word,
  input  logic [fba_pkg::BIT_IDX_W-1:0] bit_sel,
  input  logic                          op,
  output fba_pkg::word_stat_t           stat,
  output logic [fba_pkg::WORD_BITS-1:0] new_word
);

  logic [fba_pkg::WORD_BITS-1:0] low_onehot;
  logic [fba_pkg::BIT_IDX_W-1:0] low_idx;

  // Isolate the lowest clear bit
  assign low_onehot = ~word & (word + fba_pkg::WORD_BITS'(1));

  // Encode the one-hot position
  always_comb begin
    low_idx = '0;
    for (int i = 0; i < fba_pkg::WORD_BITS; i++) begin
      if (low_onehot[i]) begin
        low_idx = low_idx | fba_pkg::BIT_IDX_W'(i);
      end
    end
  end

  assign stat.full    = (word == '1);
  assign stat.low_idx = low_idx;
  assign stat.bit_val = word[bit_sel];

  // Mark the lowest free bit or release the selected one
  always_comb begin
    case (op)
      fba_pkg::WOP_MARK: new_word = word | low_onehot;
      fba_pkg::WOP_FREE: new_word = word & ~(fba_pkg::WORD_BITS'(1) << bit_sel);
      default:           new_word = word;
    endcase
  end

endmodule

FILE: hw/rtl/frame_bitmap_allocator_top.sv
// Top level of the frame bitmap allocator: sequencer, bitmap RAM and word unit.
// Steps: an allocation reads words from 0 in ST_SCAN until one has a free bit, marks it
// in ST_MARK, then loads the result in ST_PUSH; when all searched words are full it goes
// from ST_SCAN to ST_PUSH; free and test pass ST_FREE or ST_TEST, then ST_PUSH; an occupied
// entry, unknown mode or no search goes straight to ST_PUSH. One request at a time:
// s_tready returns as the result loads; a waiting result stalls the input.
// Synchronous reset clears the per-word valid bits, so the bitmap reads as free, and sets
// frame_limit to 4096; no clearing pass is needed.
module frame_bitmap_allocator_top #(
  parameter int FRAME_COUNT = fba_pkg::FRAME_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // page_frame[11:0], frame_number[23:12], writable[24],
                                 // kernel_page[25], zero[31:26]
  input  logic [1:0]  s_tuser,   // mode[1:0]
  // Result channel
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // frame_out[11:0], present[12], rw_bit[13], user_bit[14],
                                 // status[16:15], frame_used[17], zero[23:18]
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data   // frame_limit[12:0]
);

  localparam int MAP_WORDS  = FRAME_COUNT / fba_pkg::WORD_BITS;
  localparam int USED_WORDS = (MAP_WORDS < fba_pkg::MAX_WORDS) ? MAP_WORDS
                                                               : fba_pkg::MAX_WORDS;
  localparam int AW         = (USED_WORDS > 1) ? $clog2(USED_WORDS) : 1;
  localparam int CW         = fba_pkg::CNT_W;
  localparam int FB         = fba_pkg::FRAME_BITS;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_MARK = 3'd2;
  localparam logic [2:0] ST_FREE = 3'd3;
  localparam logic [2:0] ST_TEST = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  logic [2:0]                    state, state_next;
  logic [fba_pkg::LIMIT_W-1:0]   frame_limit;
  logic [fba_pkg::BIT_IDX_W-1:0] bit_q, bit_next;
  logic                          wr_q, kern_q;
  fba_pkg::result_t              res_q, res_next;
  fba_pkg::result_t              out_q;
  logic [USED_WORDS-1:0]         vld;
  logic [AW-1:0]                 rd_addr, rd_addr_q;
  logic                          rd_en;
  logic                          ram_we;
  logic [fba_pkg::WORD_BITS-1:0] ram_rdata, word_eff, new_word;
  fba_pkg::word_stat_t           stat;
  logic                          wop;

  logic [fba_pkg::MODE_W-1:0]    in_mode;
  logic [FB-1:0]                 in_page, in_fnum, req_frame;
  logic [FB-fba_pkg::BIT_IDX_W-1:0] req_word;
  logic                          req_in_range;
  logic [CW-1:0]                 lim_words, scan_n;
  logic                          scan_last;

  // Unpack the request
  assign in_mode   = s_tuser;
  assign in_page   = s_tdata[11:0];
  assign in_fnum   = s_tdata[23:12];
  assign req_frame = (in_mode == fba_pkg::MODE_FREE) ? in_page : in_fnum;
  assign req_word  = req_frame[FB-1:fba_pkg::BIT_IDX_W];
  assign req_in_range = ({1'b0, req_word} < CW'(USED_WORDS));

  // Number of whole words searched
  assign lim_words = frame_limit[fba_pkg::LIMIT_W-1:fba_pkg::BIT_IDX_W];
  assign scan_n    = (lim_words < CW'(USED_WORDS)) ? lim_words : CW'(USED_WORDS);
  assign scan_last = (CW'(rd_addr_q) == (scan_n - CW'(1)));

  // Never-written words read as free
  assign word_eff = vld[rd_addr_q] ? ram_rdata : '0;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign wop       = (state == ST_FREE) ? fba_pkg::WOP_FREE : fba_pkg::WOP_MARK;
  assign ram_we    = (state == ST_MARK) || (state == ST_FREE);

  fba_ram #(
    .WIDTH (fba_pkg::WORD_BITS),
    .DEPTH (USED_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (rd_addr_q),
    .wdata (new_word),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  fba_word_unit u_word (
    .word     (word_eff),
    .bit_sel  (bit_q),
    .op       (wop),
    .stat     (stat),
    .new_word (new_word)
  );

  // Sequence one request
  always_comb begin
    state_next = state;
    res_next   = res_q;
    bit_next   = bit_q;
    rd_en      = 1'b0;
    rd_addr    = rd_addr_q;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          res_next = '0;
          bit_next = req_frame[fba_pkg::BIT_IDX_W-1:0];
          case (in_mode)
            fba_pkg::MODE_ALLOC: begin
              if (in_page != '0) begin
                res_next.frame_out = in_page;
                res_next.status    = fba_pkg::STATUS_HELD;
                state_next         = ST_PUSH;
              end else if (scan_n == '0) begin
                res_next.status = fba_pkg::STATUS_FULL;
                state_next      = ST_PUSH;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = ST_SCAN;
              end
            end
            fba_pkg::MODE_FREE, fba_pkg::MODE_TEST: begin
              if (req_in_range) begin
                rd_en      = 1'b1;
                rd_addr    = req_word[AW-1:0];
                state_next = (in_mode == fba_pkg::MODE_FREE) ? ST_FREE : ST_TEST;
              end else begin
                state_next = ST_PUSH;
              end
            end
            default: state_next = ST_PUSH;
          endcase
        end
      end
      ST_SCAN: begin
        if (!stat.full) begin
          state_next = ST_MARK;
        end else if (scan_last) begin
          res_next.status = fba_pkg::STATUS_FULL;
          state_next      = ST_PUSH;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_addr_q + AW'(1);
        end
      end
      ST_MARK: begin
        res_next.frame_out = FB'({rd_addr_q, stat.low_idx});
        res_next.present   = 1'b1;
        res_next.rw_bit    = wr_q;
        res_next.user_bit  = ~kern_q;
        res_next.status    = fba_pkg::STATUS_DONE;
        state_next         = ST_PUSH;
      end
      ST_FREE: state_next = ST_PUSH;
      ST_TEST: begin
        res_next.frame_used = stat.bit_val;
        state_next          = ST_PUSH;
      end
      ST_PUSH: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      m_tvalid    <= 1'b0;
      vld         <= '0;
      frame_limit <= fba_pkg::LIMIT_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        frame_limit <= cfg_data;
      end
      if (ram_we) begin
        vld[rd_addr_q] <= 1'b1;
      end
      if (state == ST_PUSH && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    res_q <= res_next;
    bit_q <= bit_next;
    if (rd_en) begin
      rd_addr_q <= rd_addr;
    end
    if (state == ST_IDLE && s_tvalid) begin
      wr_q   <= s_tdata[24];
      kern_q <= s_tdata[25];
    end
    if (state == ST_PUSH && (!m_tvalid || m_tready)) begin
      out_q <= res_q;
    end
  end

  // Pack the result
  assign m_tdata = {6'b0, out_q.frame_used, out_q.status, out_q.user_bit,
                    out_q.rw_bit, out_q.present, out_q.frame_out};

  // Bitmap writes happen only when marking or releasing a frame
  a_we_state: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == ST_MARK || state == ST_FREE))
    else $error("bitmap write outside mark or free");

  // The scan never looks past the search bound
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (CW'(rd_addr_q) < scan_n))
    else $error("scan address beyond search bound");

  // A word chosen for marking has a free bit
  a_mark_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MARK) |-> !stat.full)
    else $error("marking a full word");

  // A delivered result never claims presence with a failure status
  a_res_consistent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_q.present && out_q.status != fba_pkg::STATUS_DONE))
    else $error("present result with failure status");

endmodule
